// ===== sv/cpsm_pkg.sv =====
// shared types and constants of the capture period speed meter
package cpsm_pkg;

  // width of the speed numerator and of the divider quotient
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 8'd3;

  // configuration reset values
  localparam logic [15:0]      MIN_PERIOD_RST    = 16'd100;
  localparam logic [7:0]       TIMEOUT_TICKS_RST = 8'd10;
  localparam logic [NUM_W-1:0] TICKS_PER_MIN_RST = 32'd60000000;
  localparam logic [7:0]       PULSES_PER_REV_RST = 8'd6;

  // item kinds carried in the input tuser bit
  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/cpsm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module cpsm_div import cpsm_pkg::*; #(
  parameter int unsigned DIV_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [NUM_W-1:0] quotient_o,
  output div_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] divisor_q, divisor_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] work_q, work_d;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           fits;

  // one shift and trial subtract
  assign shifted = {rem_q, work_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, divisor_q};
  assign fits    = shifted >= {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    work_d    = work_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      divisor_d = divisor_i;
      rem_d     = '0;
      work_d    = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      work_d = {work_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    work_q    <= work_d;
  end

  assign quotient_o  = work_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== sv/capture_period_speed_meter_unit.sv =====
// tachometer: capture period to rpm through one iterative divider
// sequence: a tick or a rejected capture goes from idle straight to the write state; a valid
// capture passes the product state, the 32 divider steps and the write state before its result shows
// input: an item is taken only in idle, so no new item is taken until the last result is loaded
// into the output register, and the write state waits while a result is stalled at the output
// reset: asynchronous active low, config back to defaults, speed, count, capture zero
module capture_period_speed_meter_unit import cpsm_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NUM_W-1:0]     cfg_data_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [15:0] capture_value
  input  logic [0:0]           s_axis_tuser,  // [0] func
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SPEED_W-1:0]   m_axis_tdata,  // [23:0] speed_rpm
  output logic [0:0]           m_axis_tuser   // [0] updated
);

  localparam int unsigned PW    = TIMER_BITS + 1;
  localparam int unsigned DIV_W = PW + 8;
  localparam int unsigned CMPW  = (PW > 16) ? PW : 16;
  localparam logic [PW-1:0] FULL_SPAN = {1'b1, {TIMER_BITS{1'b0}}};

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [15:0]      min_period_q;
  logic [7:0]       timeout_q;
  logic [NUM_W-1:0] tpm_q;
  logic [7:0]       ppr_q;

  logic [1:0]         state_q, state_d;
  logic [15:0]        last_q, last_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [7:0]         idle_q, idle_d;
  logic               upd_q, upd_d;
  logic [PW-1:0]      period_q, period_d;
  logic               out_valid_q, out_valid_d;
  logic [SPEED_W-1:0] out_speed_q, out_speed_d;
  logic               out_upd_q, out_upd_d;

  logic [31:0]           cap_ext, prev_ext;
  logic [TIMER_BITS-1:0] cap_t, prev_t;
  logic [PW-1:0]         period;
  logic                  glitch;
  logic [7:0]            idle_inc;
  logic [DIV_W-1:0]      divisor;
  logic                  div_start;
  logic [NUM_W-1:0]      quotient;
  div_stat_t             div_stat;
  logic [SPEED_W-1:0]    speed_sat;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= MIN_PERIOD_RST;
      timeout_q    <= TIMEOUT_TICKS_RST;
      tpm_q        <= TICKS_PER_MIN_RST;
      ppr_q        <= PULSES_PER_REV_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_PERIOD:     min_period_q <= cfg_data_i[15:0];
        REG_TIMEOUT_TICKS:  timeout_q    <= cfg_data_i[7:0];
        REG_TICKS_PER_MIN:  tpm_q        <= cfg_data_i;
        REG_PULSES_PER_REV: ppr_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // forward period across the timer wrap
  assign cap_ext  = {16'd0, s_axis_tdata};
  assign prev_ext = {16'd0, last_q};
  assign cap_t    = cap_ext[TIMER_BITS-1:0];
  assign prev_t   = prev_ext[TIMER_BITS-1:0];
  assign period   = (cap_t > prev_t) ? ({1'b0, cap_t} - {1'b0, prev_t})
                                     : ({1'b0, cap_t} + FULL_SPAN - {1'b0, prev_t});
  assign glitch   = CMPW'(period) < CMPW'(min_period_q);
  assign idle_inc = idle_q + 8'd1;

  // period times pulses, registered inside the divider
  assign divisor = DIV_W'(period_q) * DIV_W'(ppr_q);

  cpsm_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tpm_q),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // clamp to the 24-bit speed range
  assign speed_sat = (quotient[NUM_W-1:SPEED_W] != '0) ? SPEED_MAX : quotient[SPEED_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    speed_d     = speed_q;
    idle_d      = idle_q;
    upd_d       = upd_q;
    period_d    = period_q;
    out_valid_d = out_valid_q;
    out_speed_d = out_speed_q;
    out_upd_d   = out_upd_q;
    div_start   = 1'b0;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] == FUNC_TICK) begin
            if (idle_inc >= timeout_q) begin
              speed_d = '0;
              idle_d  = '0;
              upd_d   = 1'b1;
            end else begin
              idle_d = idle_inc;
              upd_d  = 1'b0;
            end
            state_d = ST_WRITE;
          end else if (glitch) begin
            upd_d   = 1'b0;
            state_d = ST_WRITE;
          end else begin
            last_d   = 16'(cap_t);
            idle_d   = '0;
            period_d = period;
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          speed_d = speed_sat;
          upd_d   = 1'b1;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_speed_d = speed_q;
          out_upd_d   = upd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      speed_q     <= '0;
      idle_q      <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      speed_q     <= speed_d;
      idle_q      <= idle_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    out_speed_q <= out_speed_d;
    out_upd_q   <= out_upd_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_speed_q;
  assign m_axis_tuser[0] = out_upd_q;

endmodule

// ===== sv/cpsm_checker.sv =====
// port-level checks of the speed meter and their bind
module cpsm_checker import cpsm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [SPEED_W-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  logic [SPEED_W-1:0] last_speed_q;

  // speed of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_speed_q <= m_axis_tdata;
    end
  end

  // block is busy right after it takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // a new result only comes from an item in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared with no item in work");

  // a result that did not update repeats the held speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tuser[0]) |-> (m_axis_tdata == last_speed_q))
    else $error("held speed changed without an update");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result dropped or changed");

endmodule

bind capture_period_speed_meter_unit cpsm_checker u_cpsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
